// ===== hw/rtl/ptssd_pkg.sv =====
// shared widths, register indexes and region codes for the point to seed segment distance block
// no dependencies
package ptssd_pkg;

    localparam int COORD_BITS = 20;

    localparam int CW   = COORD_BITS;
    localparam int VW   = CW + 1;        // point minus centre
    localparam int EW   = CW + 2;        // point to end point offset
    localparam int DSQW = 2 * CW;        // one squared direction component
    localparam int DDW  = 2 * CW + 1;    // |D|^2
    localparam int PW   = 2 * CW + 1;    // d * v product
    localparam int TW   = 2 * CW + 3;    // dot product t
    localparam int MW   = 2 * CW + 2;    // cross product component and its magnitude
    localparam int HW   = MW / 2;        // half of a magnitude for partial products
    localparam int NW   = 2 * MW + 2;    // |D x V|^2
    localparam int RW   = 2 * CW + 4;    // radicand, also the quotient width
    localparam int QW   = RW;
    localparam int RTW  = RW / 2;        // square root width

    localparam int DIST_W = 22;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam int MXW = (RTW > DIST_W) ? RTW : DIST_W;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z  = 3'd5;

    localparam logic [1:0] RGN_BESIDE = 2'd0;
    localparam logic [1:0] RGN_FAR    = 2'd1;
    localparam logic [1:0] RGN_NEAR   = 2'd2;

    typedef struct packed {
        logic [1:0] region;
        logic       degen;
    } t_side;

    // pipeline depth from an accepted point to its result strobe
    localparam int LATENCY = QW + RTW + 7;

endpackage

// ===== hw/rtl/point_to_seed_segment_distance.sv =====
// distance from a streamed space point to the configured seed segment
// depends on ptssd_pkg; fully pipelined, restoring divider and square root one bit per stage
// five arithmetic stages feed the divider, which settles one quotient bit per stage, then the
//   square root settles one root bit per stage ahead of the output register
// throughput: one point per cycle, busy never rises; the receiver cannot stall
// reset clears the seed and direction registers to zero and empties the pipeline
module point_to_seed_segment_distance import ptssd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [CW-1:0]    i_point_x,
    input  logic signed [CW-1:0]    i_point_y,
    input  logic signed [CW-1:0]    i_point_z,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CW-1:0]           i_cfg_data,
    output logic                    o_valid,
    output logic [DIST_W-1:0]       o_distance,
    output logic [1:0]              o_region,
    output logic                    o_degenerate
);

    logic signed [CW-1:0] r_seed [0:2];
    logic signed [CW-1:0] r_dir  [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_seed[i] <= '0;
                r_dir[i]  <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SEED_X: r_seed[0] <= i_cfg_data;
                REG_SEED_Y: r_seed[1] <= i_cfg_data;
                REG_SEED_Z: r_seed[2] <= i_cfg_data;
                REG_DIR_X:  r_dir[0]  <= i_cfg_data;
                REG_DIR_Y:  r_dir[1]  <= i_cfg_data;
                REG_DIR_Z:  r_dir[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic w_acc;
    assign w_acc = start && !busy;

    logic signed [CW-1:0] w_pt [0:2];
    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    // stage 1: offsets and squared direction
    logic                   r1_vld;
    logic signed [VW-1:0]   r1_v   [0:2];
    logic signed [EW-1:0]   r1_ef  [0:2];
    logic signed [EW-1:0]   r1_en  [0:2];
    logic signed [CW-1:0]   r1_d   [0:2];
    logic [DSQW-1:0]        r1_dsq [0:2];
    // stage 2: products
    logic                   r2_vld;
    logic [DDW-1:0]         r2_dd;
    logic signed [PW-1:0]   r2_tp  [0:2];
    logic signed [PW-1:0]   r2_cp  [0:5];
    logic [RW-1:0]          r2_efq [0:2];
    logic [RW-1:0]          r2_enq [0:2];
    // stage 3: dot product, cross magnitudes, end point distances
    logic                   r3_vld;
    logic [DDW-1:0]         r3_dd;
    logic signed [TW-1:0]   r3_t;
    logic [MW-1:0]          r3_cm  [0:2];
    logic [RW-1:0]          r3_efs;
    logic [RW-1:0]          r3_ens;
    // stage 4: region decision and partial products of the cross squares
    logic                   r4_vld;
    logic [DDW-1:0]         r4_dd;
    t_side                  r4_side;
    logic [RW-1:0]          r4_esq;
    logic [2*HW-1:0]        r4_hh  [0:2];
    logic [2*HW-1:0]        r4_hl  [0:2];
    logic [2*HW-1:0]        r4_ll  [0:2];

    logic signed [TW-1:0]   w_dd_s;
    assign w_dd_s = TW'($signed({1'b0, r3_dd}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= w_acc;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_v[i]   <= VW'(w_pt[i]) - VW'(r_seed[i]);
            r1_ef[i]  <= EW'(r_seed[i]) + EW'(r_dir[i]) - EW'(w_pt[i]);
            r1_en[i]  <= EW'(r_seed[i]) - EW'(r_dir[i]) - EW'(w_pt[i]);
            r1_d[i]   <= r_dir[i];
            r1_dsq[i] <= DSQW'(r_dir[i] * r_dir[i]);
        end

        r2_dd <= DDW'(r1_dsq[0]) + DDW'(r1_dsq[1]) + DDW'(r1_dsq[2]);
        for (int i = 0; i < 3; i++) begin
            r2_tp[i]  <= PW'(r1_d[i]) * PW'(r1_v[i]);
            r2_efq[i] <= RW'(r1_ef[i] * r1_ef[i]);
            r2_enq[i] <= RW'(r1_en[i] * r1_en[i]);
        end
        r2_cp[0] <= PW'(r1_d[1]) * PW'(r1_v[2]);
        r2_cp[1] <= PW'(r1_d[2]) * PW'(r1_v[1]);
        r2_cp[2] <= PW'(r1_d[2]) * PW'(r1_v[0]);
        r2_cp[3] <= PW'(r1_d[0]) * PW'(r1_v[2]);
        r2_cp[4] <= PW'(r1_d[0]) * PW'(r1_v[1]);
        r2_cp[5] <= PW'(r1_d[1]) * PW'(r1_v[0]);

        r3_dd  <= r2_dd;
        r3_t   <= TW'(r2_tp[0]) + TW'(r2_tp[1]) + TW'(r2_tp[2]);
        for (int i = 0; i < 3; i++) begin
            logic signed [MW-1:0] c;
            c = MW'(r2_cp[2*i]) - MW'(r2_cp[2*i+1]);
            r3_cm[i] <= c[MW-1] ? MW'(-c) : MW'(c);
        end
        // squared end distances stay below 2^(RW-1)
        r3_efs <= r2_efq[0] + r2_efq[1] + r2_efq[2];
        r3_ens <= r2_enq[0] + r2_enq[1] + r2_enq[2];

        r4_dd <= r3_dd;
        r4_side.degen <= (r3_dd == '0);
        if (r3_dd == '0) begin
            r4_side.region <= RGN_BESIDE;
            r4_esq         <= r3_efs;
        end else if (r3_t > w_dd_s) begin
            r4_side.region <= RGN_FAR;
            r4_esq         <= r3_efs;
        end else if (r3_t < -w_dd_s) begin
            r4_side.region <= RGN_NEAR;
            r4_esq         <= r3_ens;
        end else begin
            r4_side.region <= RGN_BESIDE;
            r4_esq         <= r3_efs;
        end
        for (int i = 0; i < 3; i++) begin
            r4_hh[i] <= r3_cm[i][MW-1:HW] * r3_cm[i][MW-1:HW];
            r4_hl[i] <= r3_cm[i][MW-1:HW] * r3_cm[i][HW-1:0];
            r4_ll[i] <= r3_cm[i][HW-1:0] * r3_cm[i][HW-1:0];
        end
    end

    // cross square sum, then restoring divider by |D|^2, one quotient bit per stage
    logic [NW-1:0] w_num;
    always_comb begin
        w_num = '0;
        for (int i = 0; i < 3; i++) begin
            w_num = w_num + (NW'(r4_hh[i]) << MW) + (NW'(r4_hl[i]) << (HW + 1))
                    + NW'(r4_ll[i]);
        end
    end

    logic             r_dv_vld  [0:QW];
    logic [DDW-1:0]   r_dv_rem  [0:QW];
    logic [QW-1:0]    r_dv_num  [0:QW];
    logic [QW-1:0]    r_dv_q    [0:QW];
    logic [DDW-1:0]   r_dv_dd   [0:QW];
    t_side            r_dv_side [0:QW];
    logic [RW-1:0]    r_dv_esq  [0:QW];

    for (genvar k = 0; k <= QW; k++) begin : g_div
        if (k == 0) begin : g_load
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[0] <= 1'b0;
                end else begin
                    r_dv_vld[0] <= r4_vld;
                end
            end
            always_ff @(posedge i_clk) begin
                // the high part is below |D|^2 since the quotient fits QW bits
                r_dv_rem[0]  <= w_num[QW+DDW-1:QW];
                r_dv_num[0]  <= w_num[QW-1:0];
                r_dv_q[0]    <= '0;
                r_dv_dd[0]   <= r4_dd;
                r_dv_side[0] <= r4_side;
                r_dv_esq[0]  <= r4_esq;
            end
        end else begin : g_step
            logic [DDW:0] w_sh;
            logic [DDW:0] w_sub;
            assign w_sh  = {r_dv_rem[k-1], r_dv_num[k-1][QW-1]};
            assign w_sub = w_sh - {1'b0, r_dv_dd[k-1]};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[k] <= 1'b0;
                end else begin
                    r_dv_vld[k] <= r_dv_vld[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_sh >= {1'b0, r_dv_dd[k-1]}) begin
                    r_dv_rem[k] <= w_sub[DDW-1:0];
                    r_dv_q[k]   <= {r_dv_q[k-1][QW-2:0], 1'b1};
                end else begin
                    r_dv_rem[k] <= w_sh[DDW-1:0];
                    r_dv_q[k]   <= {r_dv_q[k-1][QW-2:0], 1'b0};
                end
                r_dv_num[k]  <= r_dv_num[k-1] << 1;
                r_dv_dd[k]   <= r_dv_dd[k-1];
                r_dv_side[k] <= r_dv_side[k-1];
                r_dv_esq[k]  <= r_dv_esq[k-1];
            end
        end
    end

    // integer square root, one root bit per stage
    logic             r_sq_vld  [0:RTW];
    logic [RTW+1:0]   r_sq_rem  [0:RTW];
    logic [RTW-1:0]   r_sq_root [0:RTW];
    logic [RW-1:0]    r_sq_rad  [0:RTW];
    t_side            r_sq_side [0:RTW];

    for (genvar k = 0; k <= RTW; k++) begin : g_sqrt
        if (k == 0) begin : g_load
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[0] <= 1'b0;
                end else begin
                    r_sq_vld[0] <= r_dv_vld[QW];
                end
            end
            always_ff @(posedge i_clk) begin
                r_sq_rem[0]  <= '0;
                r_sq_root[0] <= '0;
                r_sq_rad[0]  <= (r_dv_side[QW].region == RGN_BESIDE) ? r_dv_q[QW]
                                                                     : r_dv_esq[QW];
                r_sq_side[0] <= r_dv_side[QW];
            end
        end else begin : g_step
            logic [RTW+3:0] w_sh;
            logic [RTW+3:0] w_trial;
            logic [RTW+3:0] w_diff;
            assign w_sh    = {r_sq_rem[k-1], r_sq_rad[k-1][RW-1:RW-2]};
            assign w_trial = {2'b00, r_sq_root[k-1], 2'b01};
            assign w_diff  = w_sh - w_trial;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k] <= 1'b0;
                end else begin
                    r_sq_vld[k] <= r_sq_vld[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_sh >= w_trial) begin
                    r_sq_rem[k]  <= w_diff[RTW+1:0];
                    r_sq_root[k] <= {r_sq_root[k-1][RTW-2:0], 1'b1};
                end else begin
                    r_sq_rem[k]  <= w_sh[RTW+1:0];
                    r_sq_root[k] <= {r_sq_root[k-1][RTW-2:0], 1'b0};
                end
                r_sq_rad[k]  <= r_sq_rad[k-1] << 2;
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // output register with saturation
    logic             r_o_vld;
    logic [DIST_W-1:0] r_o_dist;
    logic [1:0]       r_o_region;
    logic             r_o_degen;
    logic [MXW-1:0]   w_root_x;

    assign w_root_x = MXW'(r_sq_root[RTW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_sq_vld[RTW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_region <= r_sq_side[RTW].region;
        r_o_degen  <= r_sq_side[RTW].degen;
        if (r_sq_side[RTW].degen || (w_root_x > MXW'(DIST_MAX))) begin
            r_o_dist <= DIST_MAX;
        end else begin
            r_o_dist <= w_root_x[DIST_W-1:0];
        end
    end

    assign o_valid      = r_o_vld;
    assign o_distance   = r_o_dist;
    assign o_region     = r_o_region;
    assign o_degenerate = r_o_degen;

    a_degen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_distance == DIST_MAX && o_region == RGN_BESIDE)
        else $error("degenerate beat without saturated distance");

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_region == RGN_BESIDE || o_region == RGN_FAR || o_region == RGN_NEAR)
        else $error("region code out of range");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_acc, LATENCY))
        else $error("result beat without a matching accepted point");

endmodule
